FILE: src/rfr_pkg.sv
// Shared types, constants and the CRC-16 step for the RTU frame receiver.
package rfr_pkg;

  // Frame buffer depth and the counter widths that follow from it.
  localparam int FRAME_BYTES = 64;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // Fixed field widths of the ports.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int BYTE_IDX_W  = 6;
  localparam int FRAME_LEN_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE    = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  OWN_ADDR_RST   = 8'd1;
  localparam logic [7:0]  BCAST_ADDR_RST = 8'd0;
  localparam logic [15:0] SILENCE_RST    = 16'd70;

  // Input item type codes.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result kind codes.
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Reject reason codes.
  localparam logic [1:0] REASON_NONE = 2'd0;
  localparam logic [1:0] REASON_ADDR = 2'd1;
  localparam logic [1:0] REASON_CRC  = 2'd2;

  // Modbus CRC-16 constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_REJ
  } rfr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // an input item is taken this cycle
    logic idx_clr;    // restart the readout index
    logic idx_inc;    // step the readout index
    logic rd_en;      // read the buffer at the readout index
    logic load_byte;  // load a frame byte into the output register
    logic load_rej;   // load a reject status into the output register
  } rfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_frame;  // the offered item ends the current frame
    logic reject;     // the frame so ended fails a check
    logic last_byte;  // the readout index is at the final byte
    logic out_free;   // the output register can take a result
  } rfr_sts_t;

  // Fold one byte into a reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/rfr_datapath.sv
// Datapath: configuration, frame buffer, CRC, silence timer and output register.
module rfr_datapath import rfr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rfr_cmd_t               cmd_i,
  output rfr_sts_t               sts_o,
  input  logic                   req_type_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic [7:0]             data_byte_o,
  output logic [BYTE_IDX_W-1:0]  byte_index_o,
  output logic [FRAME_LEN_W-1:0] frame_len_o,
  output logic [1:0]             reject_reason_o,
  output logic                   last_o
);

  // Configuration registers.
  logic [7:0]  own_q, bcast_q;
  logic [15:0] silence_q;

  // Frame state.
  logic [7:0]       mem_q [FRAME_BYTES];
  logic [CNT_W-1:0] count_q;
  logic [15:0]      crc_q;
  logic [15:0]      timer_q;
  logic             run_q;
  logic [7:0]       first_q;

  // Ended frame and readout.
  logic [CNT_W-1:0] len_q;
  logic [1:0]       reason_q;
  logic [IDX_W-1:0] idx_q;
  logic [7:0]       rd_q;

  // Output register.
  logic                   out_valid_q;
  logic                   kind_q;
  logic [7:0]             data_q;
  logic [BYTE_IDX_W-1:0]  bidx_q;
  logic [FRAME_LEN_W-1:0] flen_q;
  logic [1:0]             oreason_q;
  logic                   last_q;

  // Next-value terms for the offered item.
  logic [15:0]      crc_fold_d;
  logic [CNT_W-1:0] count_inc;
  logic [7:0]       first_sel;
  logic [15:0]      timer_inc;
  logic             end_now;
  logic [15:0]      crc_end;
  logic [7:0]       first_end;
  logic [CNT_W-1:0] len_end;
  logic             addr_bad, crc_bad;
  logic [1:0]       reason_end;
  logic             is_byte;

  // Work out whether the offered item ends the frame, and how it is judged.
  always_comb begin
    is_byte    = (req_type_i == REQ_BYTE);
    crc_fold_d = crc_fold(crc_q, rx_byte_i);
    count_inc  = count_q + CNT_W'(1);
    first_sel  = (count_q == '0) ? rx_byte_i : first_q;
    timer_inc  = (timer_q != 16'hFFFF) ? timer_q + 16'd1 : timer_q;
    if (is_byte) begin
      end_now   = (count_inc == CNT_W'(FRAME_BYTES));
      crc_end   = crc_fold_d;
      first_end = first_sel;
      len_end   = count_inc;
    end else begin
      end_now   = run_q && (timer_inc >= silence_q);
      crc_end   = crc_q;
      first_end = first_q;
      len_end   = count_q;
    end
    addr_bad = (first_end != own_q) && (first_end != bcast_q);
    crc_bad  = (crc_end != 16'd0);
    if (addr_bad) begin
      reason_end = REASON_ADDR;
    end else if (crc_bad) begin
      reason_end = REASON_CRC;
    end else begin
      reason_end = REASON_NONE;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.end_frame = end_now;
    sts_o.reject    = addr_bad || crc_bad;
    sts_o.last_byte = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= OWN_ADDR_RST;
      bcast_q   <= BCAST_ADDR_RST;
      silence_q <= SILENCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OWN_ADDR:   own_q     <= cfg_data_i[7:0];
        CFG_BCAST_ADDR: bcast_q   <= cfg_data_i[7:0];
        CFG_SILENCE:    silence_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state update for each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      crc_q    <= CRC_INIT;
      timer_q  <= '0;
      run_q    <= 1'b0;
      first_q  <= '0;
      len_q    <= '0;
      reason_q <= REASON_NONE;
    end else if (cmd_i.accept) begin
      if (end_now) begin
        count_q  <= '0;
        crc_q    <= CRC_INIT;
        timer_q  <= '0;
        run_q    <= 1'b0;
        len_q    <= len_end;
        reason_q <= reason_end;
      end else if (is_byte) begin
        count_q <= count_inc;
        crc_q   <= crc_fold_d;
        timer_q <= '0;
        run_q   <= 1'b1;
        first_q <= first_sel;
      end else if (run_q) begin
        timer_q <= timer_inc;
      end
    end
  end

  // Frame buffer: written at the fill count, read at the readout index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_byte) begin
      mem_q[count_q[IDX_W-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  // Readout index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Output register holds one result until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_BYTE;
      data_q      <= '0;
      bidx_q      <= '0;
      flen_q      <= '0;
      oreason_q   <= REASON_NONE;
      last_q      <= 1'b0;
    end else if (cmd_i.load_rej) begin
      out_valid_q <= 1'b1;
      kind_q      <= KIND_REJECT;
      data_q      <= '0;
      bidx_q      <= '0;
      flen_q      <= FRAME_LEN_W'(len_q);
      oreason_q   <= reason_q;
      last_q      <= 1'b1;
    end else if (cmd_i.load_byte) begin
      out_valid_q <= 1'b1;
      kind_q      <= KIND_BYTE;
      data_q      <= rd_q;
      bidx_q      <= BYTE_IDX_W'(idx_q);
      flen_q      <= FRAME_LEN_W'(len_q);
      oreason_q   <= REASON_NONE;
      last_q      <= sts_o.last_byte;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign byte_index_o    = bidx_q;
  assign frame_len_o     = flen_q;
  assign reject_reason_o = oreason_q;
  assign last_o          = last_q;

  // The fill count never rests at a full buffer.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(FRAME_BYTES))
    else $error("frame fill count reached buffer depth");

  // A running timer implies a frame with at least one byte.
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (count_q != '0))
    else $error("silence timer runs on an empty frame");

  // A held result is dropped only after the receiver took it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result dropped without being taken");

endmodule

FILE: src/rfr_ctrl.sv
// Controller: takes items, then walks an ended frame out of the buffer.
module rfr_ctrl import rfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rfr_sts_t sts_i,
  output rfr_cmd_t cmd_o
);

  rfr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.end_frame) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = sts_i.reject ? S_REJ : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          if (sts_i.last_byte) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_READ;
          end
        end
      end
      S_REJ: begin
        if (sts_i.out_free) begin
          cmd_o.load_rej = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A failed check always leads to a single status result.
  a_rej_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.end_frame && sts_i.reject) |=> (state_q == S_REJ))
    else $error("rejected frame did not enter status state");

  // Every buffer read is followed by the load state.
  a_read_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> (state_q == S_LOAD))
    else $error("buffer read not followed by load");

  // A result is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_byte || cmd_o.load_rej) |-> sts_i.out_free)
    else $error("result loaded over a pending one");

endmodule

FILE: src/rtu_frame_receiver.sv
// Top level of the RTU frame receiver: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o): each item is a received byte
// (req_type_i low, rx_byte_i) or one 50 us timer tick (req_type_i high).
// Bytes collect in a 64-byte frame buffer with a running CRC-16; a byte
// restarts the silence timer. A tick that brings the timer to silence_ticks,
// or the byte that fills the buffer, ends the frame.
// Output channel (out_valid_o/out_ready_i): a rejected frame gives one
// status item; an accepted frame gives one item per byte, last_o on the end.
// Config (always ready): cfg_index_i 0 own address, 1 broadcast address, 2
// silence ticks. The user writes only while the block is idle, unenforced.
// An item that does not end a frame leaves input ready. An ending item
// stalls input in S_REJ on a reject, or through S_READ and S_LOAD per frame
// byte on readout, set by the single buffer read port and its registered
// read data. The first result loads from S_REJ, or after S_READ from S_LOAD.
// A stalled receiver holds the output register and pauses the readout.
// Reset clears the frame, the timer and the output register and restores the
// configuration defaults; the buffer needs no clearing.
module rtu_frame_receiver import rfr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   kind_o,
  output logic [7:0]             data_byte_o,
  output logic [BYTE_IDX_W-1:0]  byte_index_o,
  output logic [FRAME_LEN_W-1:0] frame_len_o,
  output logic [1:0]             reject_reason_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  rfr_cmd_t cmd;
  rfr_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  rfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .rx_byte_i       (rx_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .frame_len_o     (frame_len_o),
    .reject_reason_o (reject_reason_o),
    .last_o          (last_o)
  );

endmodule

FILE: tb/sv/rfr_checker.sv
// Checker for the RTU frame receiver: frame predictor and result scoreboard.
module rfr_checker import rfr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   req_type_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   kind_i,
  input  logic [7:0]             data_byte_i,
  input  logic [BYTE_IDX_W-1:0]  byte_index_i,
  input  logic [FRAME_LEN_W-1:0] frame_len_i,
  input  logic [1:0]             reject_reason_i,
  input  logic                   last_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     open_bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result item as the block should present it.
  typedef struct packed {
    logic                   kind;
    logic [7:0]             data_byte;
    logic [BYTE_IDX_W-1:0]  byte_index;
    logic [FRAME_LEN_W-1:0] frame_len;
    logic [1:0]             reason;
    logic                   last;
  } rx_result_t;

  rx_result_t frame_results_q[$];

  // Shadow copy of the configuration and the receive state.
  logic [7:0]  own_addr;
  logic [7:0]  bcast_addr;
  logic [15:0] silence_limit;
  logic [7:0]  frame_mem [FRAME_BYTES];
  int unsigned byte_cnt;
  logic [15:0] quiet_ticks;
  bit          timer_on;
  logic [15:0] crc_acc;
  int          fails = 0;

  // Modbus CRC-16, reflected, one bit per pass.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Close the open frame and queue the results it produces.
  task automatic close_frame();
    int unsigned n;
    logic [15:0] crc;
    rx_result_t r;
    n = byte_cnt;
    crc = crc_acc;
    byte_cnt = 0;
    crc_acc = CRC_INIT;
    quiet_ticks = '0;
    timer_on = 1'b0;
    if (n == 0) return;
    r = '0;
    r.frame_len = FRAME_LEN_W'(n);
    if (frame_mem[0] != own_addr && frame_mem[0] != bcast_addr) begin
      // Address mismatch wins over a bad CRC.
      r.kind = KIND_REJECT;
      r.reason = REASON_ADDR;
      r.last = 1'b1;
      frame_results_q.push_back(r);
    end else if (crc != 16'h0000) begin
      r.kind = KIND_REJECT;
      r.reason = REASON_CRC;
      r.last = 1'b1;
      frame_results_q.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        r.kind = KIND_BYTE;
        r.data_byte = frame_mem[i];
        r.byte_index = BYTE_IDX_W'(i);
        r.reason = REASON_NONE;
        r.last = (i == n - 1);
        frame_results_q.push_back(r);
      end
    end
  endtask

  // Apply one accepted input item to the shadow state.
  task automatic absorb_item(input logic req, input logic [7:0] b);
    if (req == REQ_BYTE) begin
      quiet_ticks = '0;
      timer_on = 1'b1;
      if (byte_cnt < FRAME_BYTES) begin
        frame_mem[byte_cnt] = b;
        crc_acc = crc16_step(crc_acc, b);
        byte_cnt++;
      end
      // A full buffer ends the frame at once.
      if (byte_cnt >= FRAME_BYTES) close_frame();
    end else if (timer_on) begin
      if (quiet_ticks != 16'hFFFF) quiet_ticks++;
      if (quiet_ticks >= silence_limit) close_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // Compare one accepted result item with the oldest expectation.
  task automatic check_result();
    rx_result_t e;
    if (frame_results_q.size() == 0) begin
      $error("result item with nothing expected: kind %0d data %0d index %0d len %0d",
             kind_i, data_byte_i, byte_index_i, frame_len_i);
      fails++;
      return;
    end
    e = frame_results_q.pop_front();
    check_field("kind", 8'(e.kind), 8'(kind_i));
    check_field("data_byte", e.data_byte, data_byte_i);
    check_field("byte_index", 8'(e.byte_index), 8'(byte_index_i));
    check_field("frame_len", 8'(e.frame_len), 8'(frame_len_i));
    check_field("reject_reason", 8'(e.reason), 8'(reject_reason_i));
    check_field("last", 8'(e.last), 8'(last_i));
  endtask

  // Watch the three channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr = OWN_ADDR_RST;
      bcast_addr = BCAST_ADDR_RST;
      silence_limit = SILENCE_RST;
      byte_cnt = 0;
      quiet_ticks = '0;
      timer_on = 1'b0;
      crc_acc = CRC_INIT;
      frame_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN_ADDR:   own_addr = cfg_data_i[7:0];
          CFG_BCAST_ADDR: bcast_addr = cfg_data_i[7:0];
          CFG_SILENCE:    silence_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_item(req_type_i, rx_byte_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    pending_o <= frame_results_q.size();
    open_bytes_o <= byte_cnt;
    fail_count_o <= fails;
  end

endmodule

FILE: tb/sv/tb_rtu_frame_receiver.sv
// Top of the RTU frame receiver testbench: clock, reset, stimulus and verdict.
module tb_rtu_frame_receiver;
  import rfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 20;

  typedef logic [7:0] byte_q_t [$];

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready_o;
  logic                   req_type;
  logic [7:0]             rx_byte;
  logic                   out_valid_o;
  logic                   out_ready;
  logic                   kind_o;
  logic [7:0]             data_byte_o;
  logic [BYTE_IDX_W-1:0]  byte_index_o;
  logic [FRAME_LEN_W-1:0] frame_len_o;
  logic [1:0]             reject_reason_o;
  logic                   last_o;
  logic                   cfg_valid;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int open_bytes;
  int stall_cycles;
  int sent_items;
  bit idle_on;
  logic [7:0]  cur_own;
  logic [7:0]  cur_bcast;
  logic [15:0] cur_sil;

  rtu_frame_receiver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .frame_len_o     (frame_len_o),
    .reject_reason_o (reject_reason_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  rfr_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready_o),
    .req_type_i      (req_type),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready),
    .kind_i          (kind_o),
    .data_byte_i     (data_byte_o),
    .byte_index_i    (byte_index_o),
    .frame_len_i     (frame_len_o),
    .reject_reason_i (reject_reason_o),
    .last_i          (last_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .open_bytes_o    (open_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver side: random back-pressure unless idling is switched off.
  always @(negedge clk_i) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 24);
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Modbus CRC-16 of a byte sequence, for building well-formed frames.
  function automatic void add_crc(ref byte_q_t q);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (q[i]) begin
      c = c ^ {8'h00, q[i]};
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
    end
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
  endfunction

  // Offer one input item; entered and left at a falling edge.
  task automatic push_item(input logic req, input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    // Ticks on a stopped timer are ignored, so they are not counted.
    if (req == REQ_BYTE || open_bytes != 0) sent_items++;
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) push_item(REQ_TICK, 8'($urandom));
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) push_item(REQ_BYTE, q[i]);
  endtask

  // Wait until every expected result is out, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Write all three registers; address writes carry junk in the upper byte.
  task automatic configure(input logic [7:0] own, input logic [7:0] bcast,
                           input logic [15:0] sil, input bit spare);
    write_reg(CFG_OWN_ADDR, {8'($urandom), own});
    write_reg(CFG_BCAST_ADDR, {8'($urandom), bcast});
    write_reg(CFG_SILENCE, sil);
    if (spare) write_reg(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur_own = own;
    cur_bcast = bcast;
    cur_sil = sil;
  endtask

  // Fill any open frame up to the buffer size so it ends.
  task automatic flush_open_frame();
    while (open_bytes != 0) push_item(REQ_BYTE, 8'($urandom));
  endtask

  // One random frame: mostly well formed, sometimes noisy or cut short.
  task automatic random_frame(input bit force_full);
    byte_q_t q;
    int len;
    int body_len;
    int max_gap;
    bit good;
    logic [7:0] first;
    if ($urandom_range(99) < 10) push_item(REQ_TICK, 8'($urandom));
    if (force_full || cur_sil > 40 || $urandom_range(99) < 8) begin
      len = FRAME_BYTES;
    end else begin
      len = $urandom_range(1, 10);
    end
    case ($urandom_range(3))
      0, 1: first = cur_own;
      2: first = cur_bcast;
      default: first = 8'($urandom);
    endcase
    good = force_full || ($urandom_range(99) < 80);
    body_len = (len >= 3 && good) ? len - 2 : len;
    q = {};
    q.push_back(first);
    while (q.size() < body_len) q.push_back(8'($urandom));
    if (len >= 3 && good) add_crc(q);
    // Occasionally flip one bit so a well-formed frame fails its CRC.
    if (!force_full && $urandom_range(99) < 10) begin
      body_len = $urandom_range(0, len - 1);
      q[body_len] = q[body_len] ^ (8'h01 << $urandom_range(7));
    end
    max_gap = (cur_sil - 1 > 4) ? 4 : int'(cur_sil) - 1;
    foreach (q[i]) begin
      push_item(REQ_BYTE, q[i]);
      // Ticks short of the silence count keep the frame open.
      if (i < len - 1 && cur_sil > 1 && $urandom_range(99) < 15) begin
        send_ticks($urandom_range(1, max_gap));
      end
    end
    if (len < FRAME_BYTES) begin
      if (cur_sil > 1 && $urandom_range(99) < 10) begin
        send_ticks($urandom_range(0, cur_sil - 1));
      end else begin
        send_ticks((cur_sil == 0) ? 1 : int'(cur_sil));
      end
    end else if ($urandom_range(99) < 30) begin
      push_item(REQ_TICK, 8'($urandom));
    end
  endtask

  initial begin
    byte_q_t q;
    int budget;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_BYTE;
    rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OWN_ADDR;
    cfg_data = '0;
    stall_cycles = 0;
    sent_items = 0;
    idle_on = 1'b1;
    cur_own = OWN_ADDR_RST;
    cur_bcast = BCAST_ADDR_RST;
    cur_sil = SILENCE_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with a short silence count.
    configure(8'h11, 8'h00, 16'd2, 1'b0);
    // A tick with the timer stopped does nothing.
    send_ticks(1);
    // Good frame to the own address, one tick below silence in the middle.
    q = '{8'h11, 8'hFF, 8'h00};
    add_crc(q);
    push_item(REQ_BYTE, q[0]);
    push_item(REQ_BYTE, q[1]);
    send_ticks(1);
    for (int i = 2; i < q.size(); i++) push_item(REQ_BYTE, q[i]);
    send_ticks(2);
    // Good frame to the broadcast address.
    q = '{8'h00, 8'h80};
    add_crc(q);
    send_bytes(q);
    send_ticks(2);
    // Wrong address and wrong CRC: the address is reported.
    q = '{8'h42, 8'h13, 8'h37};
    send_bytes(q);
    send_ticks(2);
    // Right address, bad CRC on a one-byte frame.
    q = '{8'h11};
    send_bytes(q);
    send_ticks(2);
    send_ticks(1);

    // Random phases, each with its own register setting.
    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: configure(8'h00, 8'hFF, 16'd1, 1'b0);
        1: configure(8'hFF, 8'h00, 16'd0, 1'b0);
        2: configure(8'($urandom), 8'($urandom), 16'($urandom_range(3, 8)), 1'b0);
        3: configure(8'h5A, 8'h5A, 16'd5, 1'b0);
        default: configure(8'($urandom), 8'($urandom), 16'hFFFF, 1'b1);
      endcase
      // One phase runs with no idling on either side.
      idle_on = (p != 2);
      budget = sent_items + PHASE_ITEMS;
      random_frame(p == 0);
      while (sent_items < budget) random_frame(1'b0);
      flush_open_frame();
    end

    settle();
    idle_on = 1'b1;
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
